@@ rtl/dbf_pkg.sv @@
// Shared types, constants and helpers for the deblocking edge sample filter.
package dbf_pkg;

  localparam int unsigned SampleBits = 8;

  typedef logic [SampleBits-1:0] smp_t;

  // Boundary strength codes
  localparam logic [2:0] BsNone   = 3'd0;
  localparam logic [2:0] BsStrong = 3'd4;

  // Plane kind
  localparam logic ModeLuma   = 1'b0;
  localparam logic ModeChroma = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [2:0]  strength;
    logic [7:0]  alpha_limit;
    logic [4:0]  beta_limit;
    logic [4:0]  clip_base;
    smp_t        p_near;
    smp_t        p_second;
    smp_t        p_third;
    smp_t        p_far;
    smp_t        q_near;
    smp_t        q_second;
    logic [15:0] q_third_far;
  } dbf_in_t;

  typedef struct packed {
    smp_t p0_out;
    smp_t p1_out;
    smp_t p2_out;
    smp_t q0_out;
    smp_t q1_out;
    smp_t q2_out;
    logic changed;
  } dbf_out_t;

  // After the gate stage
  typedef struct packed {
    smp_t       p0, p1, p2, p3;
    smp_t       q0, q1, q2, q3;
    logic [4:0] c0;
    logic       gate;
    logic       bs_strong;
    logic       chroma;
    logic       act_p;
    logic       act_q;
    logic       small_step;
  } dbf_s1_t;

  // After the filter stage
  typedef struct packed {
    smp_t              p0, p1, p2;
    smp_t              q0, q1, q2;
    logic              gate;
    logic              bs_strong;
    logic              str_p;
    logic              str_q;
    logic              wk_p;
    logic              wk_q;
    smp_t              sp0, sp1, sp2;
    smp_t              sq0, sq1, sq2;
    smp_t              ap0, aq0;
    logic signed [6:0] delta;
    logic signed [5:0] cor_p;
    logic signed [5:0] cor_q;
  } dbf_s2_t;

  function automatic smp_t abs_diff(input smp_t a, input smp_t b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

@@ rtl/dbf_gate.sv @@
// First stage: edge activity gate and side activity tests.
module dbf_gate (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  dbf_pkg::dbf_in_t data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output dbf_pkg::dbf_s1_t data_o
);
  import dbf_pkg::*;

  logic    valid_q;
  dbf_s1_t data_d, data_q;
  smp_t    d_pq, d_pp, d_qq, d_p02, d_q02;
  logic    bs_ok;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d        = '0;
    data_d.p0     = data_i.p_near;
    data_d.p1     = data_i.p_second;
    data_d.p2     = data_i.p_third;
    data_d.p3     = data_i.p_far;
    data_d.q0     = data_i.q_near;
    data_d.q1     = data_i.q_second;
    data_d.q2     = data_i.q_third_far[7:0];
    data_d.q3     = data_i.q_third_far[15:8];
    data_d.c0     = data_i.clip_base;
    d_pq          = abs_diff(data_i.p_near, data_i.q_near);
    d_pp          = abs_diff(data_i.p_near, data_i.p_second);
    d_qq          = abs_diff(data_i.q_near, data_i.q_second);
    d_p02         = abs_diff(data_i.p_near, data_i.p_third);
    d_q02         = abs_diff(data_i.q_near, data_i.q_third_far[7:0]);
    bs_ok         = (data_i.strength != BsNone) && (data_i.strength <= BsStrong);
    data_d.gate   = bs_ok && (d_pq < data_i.alpha_limit)
                    && (d_pp < {3'b000, data_i.beta_limit})
                    && (d_qq < {3'b000, data_i.beta_limit});
    data_d.bs_strong = (data_i.strength == BsStrong);
    data_d.chroma = (data_i.mode == ModeChroma);
    data_d.act_p  = d_p02 < {3'b000, data_i.beta_limit};
    data_d.act_q  = d_q02 < {3'b000, data_i.beta_limit};
    data_d.small_step = d_pq < ({2'b00, data_i.alpha_limit[7:2]} + 8'd2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ rtl/dbf_filt.sv @@
// Second stage: strong filter taps, normal filter delta and p1/q1 corrections.
module dbf_filt (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  dbf_pkg::dbf_s1_t data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output dbf_pkg::dbf_s2_t data_o
);
  import dbf_pkg::*;

  logic               valid_q;
  dbf_s2_t            data_d, data_q;
  logic [10:0]        sum_p0, sum_q0, sum_p2, sum_q2;
  logic [9:0]         sum_p1, sum_q1, sum_ap, sum_aq, sum_avg;
  logic [7:0]         avg;
  logic signed [11:0] raw, raw_sh, tc_s;
  logic [5:0]         tc;
  logic signed [10:0] crp, crq, crp_sh, crq_sh, c0_s;
  logic               wk_p, wk_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    wk_p = !data_i.chroma && data_i.act_p;
    wk_q = !data_i.chroma && data_i.act_q;

    // Strong filter taps
    sum_p0 = {3'b000, data_i.p2} + {2'b00, data_i.p1, 1'b0} + {2'b00, data_i.p0, 1'b0}
             + {2'b00, data_i.q0, 1'b0} + {3'b000, data_i.q1} + 11'd4;
    sum_q0 = {3'b000, data_i.q2} + {2'b00, data_i.q1, 1'b0} + {2'b00, data_i.q0, 1'b0}
             + {2'b00, data_i.p0, 1'b0} + {3'b000, data_i.p1} + 11'd4;
    sum_p1 = {2'b00, data_i.p2} + {2'b00, data_i.p1} + {2'b00, data_i.p0}
             + {2'b00, data_i.q0} + 10'd2;
    sum_q1 = {2'b00, data_i.q2} + {2'b00, data_i.q1} + {2'b00, data_i.q0}
             + {2'b00, data_i.p0} + 10'd2;
    sum_p2 = {2'b00, data_i.p3, 1'b0} + {2'b00, data_i.p2, 1'b0} + {3'b000, data_i.p2}
             + {3'b000, data_i.p1} + {3'b000, data_i.p0} + {3'b000, data_i.q0} + 11'd4;
    sum_q2 = {2'b00, data_i.q3, 1'b0} + {2'b00, data_i.q2, 1'b0} + {3'b000, data_i.q2}
             + {3'b000, data_i.q1} + {3'b000, data_i.q0} + {3'b000, data_i.p0} + 11'd4;
    // Three-tap average used by chroma strong filtering and by the strong filter's weak side
    sum_ap = {1'b0, data_i.p1, 1'b0} + {2'b00, data_i.p0} + {2'b00, data_i.q1} + 10'd2;
    sum_aq = {1'b0, data_i.q1, 1'b0} + {2'b00, data_i.q0} + {2'b00, data_i.p1} + 10'd2;

    // Normal filter delta, clipped to +/- tc
    raw = ((($signed({4'b0000, data_i.q0}) - $signed({4'b0000, data_i.p0}))) <<< 2)
          + ($signed({4'b0000, data_i.p1}) - $signed({4'b0000, data_i.q1})) + 12'sd4;
    raw_sh = raw >>> 3;
    tc = data_i.chroma ? ({1'b0, data_i.c0} + 6'd1)
                       : ({1'b0, data_i.c0} + {5'b00000, wk_p} + {5'b00000, wk_q});
    tc_s = $signed({6'b000000, tc});
    if (raw_sh > tc_s) begin
      data_d.delta = 7'(tc_s);
    end else if (raw_sh < -tc_s) begin
      data_d.delta = 7'(-tc_s);
    end else begin
      data_d.delta = 7'(raw_sh);
    end

    // p1/q1 corrections, clipped to +/- c0
    sum_avg = {2'b00, data_i.p0} + {2'b00, data_i.q0} + 10'd1;
    avg     = sum_avg[8:1];
    c0_s    = $signed({6'b000000, data_i.c0});
    crp = $signed({3'b000, data_i.p2}) + $signed({3'b000, avg})
          - $signed({2'b00, data_i.p1, 1'b0});
    crq = $signed({3'b000, data_i.q2}) + $signed({3'b000, avg})
          - $signed({2'b00, data_i.q1, 1'b0});
    crp_sh = crp >>> 1;
    crq_sh = crq >>> 1;
    if (crp_sh > c0_s) begin
      data_d.cor_p = 6'(c0_s);
    end else if (crp_sh < -c0_s) begin
      data_d.cor_p = 6'(-c0_s);
    end else begin
      data_d.cor_p = 6'(crp_sh);
    end
    if (crq_sh > c0_s) begin
      data_d.cor_q = 6'(c0_s);
    end else if (crq_sh < -c0_s) begin
      data_d.cor_q = 6'(-c0_s);
    end else begin
      data_d.cor_q = 6'(crq_sh);
    end

    data_d.p0     = data_i.p0;
    data_d.p1     = data_i.p1;
    data_d.p2     = data_i.p2;
    data_d.q0     = data_i.q0;
    data_d.q1     = data_i.q1;
    data_d.q2     = data_i.q2;
    data_d.gate   = data_i.gate;
    data_d.bs_strong = data_i.bs_strong;
    data_d.str_p  = !data_i.chroma && data_i.small_step && data_i.act_p;
    data_d.str_q  = !data_i.chroma && data_i.small_step && data_i.act_q;
    data_d.wk_p   = wk_p;
    data_d.wk_q   = wk_q;
    data_d.sp0    = sum_p0[10:3];
    data_d.sq0    = sum_q0[10:3];
    data_d.sp1    = sum_p1[9:2];
    data_d.sq1    = sum_q1[9:2];
    data_d.sp2    = sum_p2[10:3];
    data_d.sq2    = sum_q2[10:3];
    data_d.ap0    = sum_ap[9:2];
    data_d.aq0    = sum_aq[9:2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ rtl/dbf_sel.sv @@
// Third stage: apply deltas with saturation, pick the filter result, flag changes.
module dbf_sel (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  dbf_pkg::dbf_s2_t  data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output dbf_pkg::dbf_out_t data_o
);
  import dbf_pkg::*;

  logic               valid_q;
  dbf_out_t           data_d, data_q;
  logic signed [9:0]  wp0, wq0, wp1, wq1;
  smp_t               np0, np1, np2, nq0, nq1, nq2;
  smp_t               cp0, cq0, cp1, cq1;

  function automatic smp_t sat(input logic signed [9:0] v);
    if (v < 10'sd0) begin
      sat = '0;
    end else if (v > 10'sd255) begin
      sat = '1;
    end else begin
      sat = v[7:0];
    end
  endfunction

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    wp0 = $signed({2'b00, data_i.p0}) + 10'(data_i.delta);
    wq0 = $signed({2'b00, data_i.q0}) - 10'(data_i.delta);
    wp1 = $signed({2'b00, data_i.p1}) + 10'(data_i.cor_p);
    wq1 = $signed({2'b00, data_i.q1}) + 10'(data_i.cor_q);
    cp0 = sat(wp0);
    cq0 = sat(wq0);
    cp1 = sat(wp1);
    cq1 = sat(wq1);

    np0 = data_i.p0;
    np1 = data_i.p1;
    np2 = data_i.p2;
    nq0 = data_i.q0;
    nq1 = data_i.q1;
    nq2 = data_i.q2;
    if (data_i.gate) begin
      if (data_i.bs_strong) begin
        if (data_i.str_p) begin
          np0 = data_i.sp0;
          np1 = data_i.sp1;
          np2 = data_i.sp2;
        end else begin
          np0 = data_i.ap0;
        end
        if (data_i.str_q) begin
          nq0 = data_i.sq0;
          nq1 = data_i.sq1;
          nq2 = data_i.sq2;
        end else begin
          nq0 = data_i.aq0;
        end
      end else begin
        np0 = cp0;
        nq0 = cq0;
        if (data_i.wk_p) begin
          np1 = cp1;
        end
        if (data_i.wk_q) begin
          nq1 = cq1;
        end
      end
    end

    data_d.p0_out  = np0;
    data_d.p1_out  = np1;
    data_d.p2_out  = np2;
    data_d.q0_out  = nq0;
    data_d.q1_out  = nq1;
    data_d.q2_out  = nq2;
    data_d.changed = (np0 != data_i.p0) || (np1 != data_i.p1) || (np2 != data_i.p2)
                     || (nq0 != data_i.q0) || (nq1 != data_i.q1) || (nq2 != data_i.q2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ rtl/deblocking_edge_sample_filter_unit.sv @@
// Each accepted item passes through the gate, filter and select registers before its result is valid.
// Throughput: one edge line per cycle while the output is not stalled; three register stages (gate, filter, select).
// Each stage holds its item while the next is full, so a stall ripples back to in_ready_o.
// Reset: rst_ni is asynchronous and active low; it clears all stage valid bits only.
// Payload registers are not reset and carry no meaning while their valid bit is low.
module deblocking_edge_sample_filter_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dbf_pkg::dbf_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dbf_pkg::dbf_out_t out_item_o
);
  import dbf_pkg::*;

  // Stage-to-stage handshake and payload
  logic    s1_valid, s1_ready;
  logic    s2_valid, s2_ready;
  dbf_s1_t s1_data;
  dbf_s2_t s2_data;

  // Gate stage: absolute differences against alpha and beta, side activity
  dbf_gate u_gate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_item_i),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .data_o  (s1_data)
  );

  // Filter stage: every candidate value, computed in parallel
  dbf_filt u_filt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  // Select stage: saturate, choose, and compare against the input samples
  dbf_sel u_sel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_item_o)
  );

endmodule

@@ rtl/dbf_chk.sv @@
// Port-level checker for the deblocking edge sample filter, with its bind.
module dbf_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input dbf_pkg::dbf_in_t  in_item_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input dbf_pkg::dbf_out_t out_item_o
);

  // Hold a waiting input item until it is taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_item_i))
    else $error("input item changed while waiting");

  // Hold a result until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_item_o))
    else $error("result changed while stalled");

  // Back-pressure on the input only when the whole pipe is full behind a stalled output
  a_full_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with room in the pipeline");

  // An accepted item passes the gate, filter and select registers and shows up when the output keeps draining
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && out_ready_i) ##1 out_ready_i ##1 out_ready_i
    |=> out_valid_o)
    else $error("item missing at output after pipeline latency");

endmodule

bind deblocking_edge_sample_filter_unit dbf_chk u_dbf_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

@@ test/tb_top.sv @@
// Self-checking testbench for the deblocking edge sample filter unit.
module tb_top;
  import dbf_pkg::*;

  localparam int SampleMax  = (1 << SampleBits) - 1;
  localparam int RandLines  = 1600;
  localparam int IdleLimit  = 4000;
  localparam int DrainWait  = 12;
  localparam int PrintLimit = 40;

  typedef struct {
    dbf_in_t line;
    int      gap;
    bit      drain;
  } line_req_t;

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  dbf_in_t  in_item   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  dbf_out_t out_item;

  line_req_t pending_lines[$];
  dbf_out_t  filtered_lines[$];
  int        errors = 0;

  always #5 clk_i = ~clk_i;

  deblocking_edge_sample_filter_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  function automatic int mag(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int clamp(int lo, int hi, int v);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Filter one edge line the way the block should.
  function automatic dbf_out_t filter_line(dbf_in_t it);
    dbf_out_t r;
    int p0, p1, p2, p3, q0, q1, q2, q3;
    int alpha, beta, c0;
    int np0, np1, np2, nq0, nq1, nq2;
    int tc, delta, avg;
    bit chroma, gate_ok, near_step, act_p, act_q;
    p0 = int'(it.p_near);
    p1 = int'(it.p_second);
    p2 = int'(it.p_third);
    p3 = int'(it.p_far);
    q0 = int'(it.q_near);
    q1 = int'(it.q_second);
    q2 = int'(it.q_third_far[7:0]);
    q3 = int'(it.q_third_far[15:8]);
    alpha = int'(it.alpha_limit);
    beta  = int'(it.beta_limit);
    c0    = int'(it.clip_base);
    chroma = (it.mode == ModeChroma);
    np0 = p0; np1 = p1; np2 = p2;
    nq0 = q0; nq1 = q1; nq2 = q2;
    gate_ok = it.strength != BsNone && it.strength <= BsStrong &&
              mag(q0 - p0) < alpha && mag(q0 - q1) < beta && mag(p0 - p1) < beta;
    if (gate_ok && it.strength == BsStrong) begin
      if (chroma) begin
        np0 = (2 * p1 + p0 + q1 + 2) >> 2;
        nq0 = (2 * q1 + q0 + p1 + 2) >> 2;
      end else begin
        near_step = mag(q0 - p0) < ((alpha >> 2) + 2);
        act_p = near_step && mag(p0 - p2) < beta;
        act_q = near_step && mag(q0 - q2) < beta;
        if (act_p) begin
          np0 = (p2 + 2 * p1 + 2 * p0 + 2 * q0 + q1 + 4) >> 3;
          np1 = (p2 + p1 + p0 + q0 + 2) >> 2;
          np2 = (2 * p3 + 3 * p2 + p1 + p0 + q0 + 4) >> 3;
        end else begin
          np0 = (2 * p1 + p0 + q1 + 2) >> 2;
        end
        if (act_q) begin
          nq0 = (q2 + 2 * q1 + 2 * q0 + 2 * p0 + p1 + 4) >> 3;
          nq1 = (q2 + q1 + q0 + p0 + 2) >> 2;
          nq2 = (2 * q3 + 3 * q2 + q1 + q0 + p0 + 4) >> 3;
        end else begin
          nq0 = (2 * q1 + q0 + p1 + 2) >> 2;
        end
      end
    end else if (gate_ok) begin
      act_p = !chroma && mag(p0 - p2) < beta;
      act_q = !chroma && mag(q0 - q2) < beta;
      tc = chroma ? c0 + 1 : c0 + int'(act_p) + int'(act_q);
      // >>> on int floors negative values
      delta = clamp(-tc, tc, ((q0 - p0) * 4 + (p1 - q1) + 4) >>> 3);
      np0 = clamp(0, SampleMax, p0 + delta);
      nq0 = clamp(0, SampleMax, q0 - delta);
      avg = (p0 + q0 + 1) >> 1;
      if (act_p) np1 = clamp(0, SampleMax, p1 + clamp(-c0, c0, (p2 + avg - 2 * p1) >>> 1));
      if (act_q) nq1 = clamp(0, SampleMax, q1 + clamp(-c0, c0, (q2 + avg - 2 * q1) >>> 1));
    end
    r.p0_out = smp_t'(np0);
    r.p1_out = smp_t'(np1);
    r.p2_out = smp_t'(np2);
    r.q0_out = smp_t'(nq0);
    r.q1_out = smp_t'(nq1);
    r.q2_out = smp_t'(nq2);
    r.changed = (np0 != p0) || (np1 != p1) || (np2 != p2) ||
                (nq0 != q0) || (nq1 != q1) || (nq2 != q2);
    return r;
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 55) return 0;
    if (r < 85) return int'($urandom_range(1, 3));
    if (r < 97) return int'($urandom_range(4, 12));
    return int'($urandom_range(30, 80));
  endfunction

  function automatic int near(int v, int spread);
    return clamp(0, SampleMax, v + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  function automatic dbf_in_t make_line(bit mode, logic [2:0] bs, int alpha, int beta, int c0,
                                        int p0, int p1, int p2, int p3,
                                        int q0, int q1, int q2, int q3);
    dbf_in_t it;
    it.mode        = mode;
    it.strength    = bs;
    it.alpha_limit = 8'(alpha);
    it.beta_limit  = 5'(beta);
    it.clip_base   = 5'(c0);
    it.p_near      = smp_t'(p0);
    it.p_second    = smp_t'(p1);
    it.p_third     = smp_t'(p2);
    it.p_far       = smp_t'(p3);
    it.q_near      = smp_t'(q0);
    it.q_second    = smp_t'(q1);
    it.q_third_far = {8'(q3), 8'(q2)};
    return it;
  endfunction

  // Most lines sit close to the gate so the filters get exercised; the rest is noise.
  function automatic dbf_in_t gen_line();
    dbf_in_t it;
    int r, alpha, beta, slack, p0, q0;
    r = int'($urandom_range(0, 9));
    if (r < 7) begin
      alpha = int'($urandom_range(1, 255));
      beta  = int'($urandom_range(1, 31));
      slack = ($urandom_range(0, 7) == 0) ? 3 : 0;
      p0 = int'($urandom_range(0, 255));
      q0 = ($urandom_range(0, 1) == 1) ? near(p0, (alpha >> 2) + 1 + slack)
                                       : near(p0, alpha - 1 + slack);
      it = make_line(1'($urandom_range(0, 1)), 3'($urandom_range(1, 4)), alpha, beta,
                     int'($urandom_range(0, 31)),
                     p0, near(p0, beta - 1 + slack),
                     ($urandom_range(0, 3) != 0) ? near(p0, beta - 1 + slack)
                                                 : int'($urandom_range(0, 255)),
                     int'($urandom_range(0, 255)),
                     q0, near(q0, beta - 1 + slack),
                     ($urandom_range(0, 3) != 0) ? near(q0, beta - 1 + slack)
                                                 : int'($urandom_range(0, 255)),
                     int'($urandom_range(0, 255)));
      // now and then an unfiltered or out-of-range strength
      if ($urandom_range(0, 15) == 0) it.strength = 3'($urandom_range(0, 7));
    end else begin
      it = make_line(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                     int'($urandom_range(0, 255)), int'($urandom_range(0, 31)),
                     int'($urandom_range(0, 31)),
                     int'($urandom_range(0, 255)), int'($urandom_range(0, 255)),
                     int'($urandom_range(0, 255)), int'($urandom_range(0, 255)),
                     int'($urandom_range(0, 255)), int'($urandom_range(0, 255)),
                     int'($urandom_range(0, 255)), int'($urandom_range(0, 255)));
    end
    return it;
  endfunction

  task automatic queue_line(dbf_in_t line, int gap, bit drain);
    line_req_t req;
    req.line  = line;
    req.gap   = gap;
    req.drain = drain;
    pending_lines.push_back(req);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    if (errors < PrintLimit) $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Driver: present queued lines, idle for each line's gap after acceptance.
  int gap_left = 0;
  int cur_gap  = 0;

  always @(posedge clk_i) begin : drive_lines
    logic      nxt_valid;
    dbf_in_t   nxt_item;
    line_req_t req;
    nxt_valid = in_valid;
    nxt_item  = in_item;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        filtered_lines.push_back(filter_line(in_item));
        nxt_valid = 1'b0;
        gap_left  = cur_gap;
      end
      if (!nxt_valid && pending_lines.size() != 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!(pending_lines[0].drain && filtered_lines.size() != 0)) begin
          // hold off a drain-marked line until every result is back
          req       = pending_lines.pop_front();
          nxt_item  = req.line;
          nxt_valid = 1'b1;
          cur_gap   = req.gap;
        end
      end
    end
    in_valid <= nxt_valid;
    in_item  <= nxt_item;
  end

  // Monitor: compare each accepted result with the oldest expected line, stall at random.
  int  stall_left = 0;
  int  calm_left  = 0;
  bit  calm       = 1'b0;

  always @(posedge clk_i) begin : check_lines
    logic     nxt_ready;
    dbf_out_t want;
    nxt_ready = out_ready;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (filtered_lines.size() == 0) begin
          report_mismatch("unexpected result, p0", int'(out_item.p0_out), -1);
        end else begin
          want = filtered_lines.pop_front();
          if (out_item.p0_out != want.p0_out)
            report_mismatch("p0_out", int'(out_item.p0_out), int'(want.p0_out));
          if (out_item.p1_out != want.p1_out)
            report_mismatch("p1_out", int'(out_item.p1_out), int'(want.p1_out));
          if (out_item.p2_out != want.p2_out)
            report_mismatch("p2_out", int'(out_item.p2_out), int'(want.p2_out));
          if (out_item.q0_out != want.q0_out)
            report_mismatch("q0_out", int'(out_item.q0_out), int'(want.q0_out));
          if (out_item.q1_out != want.q1_out)
            report_mismatch("q1_out", int'(out_item.q1_out), int'(want.q1_out));
          if (out_item.q2_out != want.q2_out)
            report_mismatch("q2_out", int'(out_item.q2_out), int'(want.q2_out));
          if (out_item.changed !== want.changed)
            report_mismatch("changed", int'(out_item.changed), int'(want.changed));
        end
      end
      if (calm_left == 0) begin
        calm      = ($urandom_range(0, 3) == 0);
        calm_left = 300;
      end else begin
        calm_left--;
      end
      if (stall_left > 0) begin
        stall_left--;
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) stall_left = 1 + pick_gap();
      end
    end
    out_ready <= nxt_ready;
  end

  // Watchdog: end the run if nothing moves for too long.
  int idle_cycles = 0;

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : run
    bit burst;
    int n;
    // directed lines: pass-through cases first
    queue_line(make_line(ModeLuma, BsNone, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), pick_gap(), 1'b0);
    queue_line(make_line(ModeChroma, 3'd7, 255, 31, 31, 255, 255, 255, 255, 255, 255, 255, 255),
               pick_gap(), 1'b0);
    queue_line(make_line(ModeLuma, BsNone, 40, 10, 2, 100, 102, 104, 106, 110, 108, 106, 104),
               pick_gap(), 1'b0);
    queue_line(make_line(ModeLuma, 3'd5, 40, 10, 2, 100, 102, 104, 106, 110, 108, 106, 104),
               pick_gap(), 1'b0);
    queue_line(make_line(ModeLuma, 3'd7, 40, 10, 2, 100, 102, 104, 106, 110, 108, 106, 104),
               pick_gap(), 1'b0);
    // gate not met: alpha step, alpha zero, beta zero, p side and q side beta
    queue_line(make_line(ModeLuma, 3'd2, 5, 10, 2, 100, 101, 102, 103, 110, 109, 108, 107),
               pick_gap(), 1'b0);
    queue_line(make_line(ModeLuma, BsStrong, 0, 10, 2, 80, 80, 80, 80, 80, 80, 80, 80),
               pick_gap(), 1'b0);
    queue_line(make_line(ModeLuma, 3'd1, 50, 0, 2, 80, 80, 80, 80, 84, 84, 84, 84),
               pick_gap(), 1'b0);
    queue_line(make_line(ModeLuma, 3'd3, 50, 6, 2, 80, 90, 80, 80, 84, 84, 84, 84),
               pick_gap(), 1'b0);
    queue_line(make_line(ModeChroma, BsStrong, 50, 6, 2, 80, 80, 80, 80, 84, 74, 84, 84),
               pick_gap(), 1'b0);
    // chroma strong and normal
    queue_line(make_line(ModeChroma, BsStrong, 40, 10, 2, 100, 97, 150, 20, 108, 111, 30, 200),
               pick_gap(), 1'b0);
    queue_line(make_line(ModeChroma, 3'd2, 40, 10, 3, 100, 97, 150, 20, 108, 111, 30, 200),
               pick_gap(), 1'b0);
    // luma strong: both sides, step too large, p side only, q side only
    queue_line(make_line(ModeLuma, BsStrong, 40, 10, 2, 100, 98, 96, 90, 106, 108, 110, 120),
               pick_gap(), 1'b0);
    queue_line(make_line(ModeLuma, BsStrong, 40, 10, 2, 100, 98, 96, 90, 120, 122, 124, 130),
               pick_gap(), 1'b0);
    queue_line(make_line(ModeLuma, BsStrong, 40, 10, 2, 100, 98, 96, 90, 106, 108, 150, 160),
               pick_gap(), 1'b0);
    queue_line(make_line(ModeLuma, BsStrong, 40, 10, 2, 100, 98, 40, 30, 106, 108, 110, 120),
               pick_gap(), 1'b0);
    // luma normal: both sides active, neither, clip base at its 5-bit maximum
    queue_line(make_line(ModeLuma, 3'd1, 40, 10, 4, 100, 95, 92, 90, 112, 117, 119, 121),
               pick_gap(), 1'b0);
    queue_line(make_line(ModeLuma, 3'd2, 40, 10, 4, 100, 95, 40, 90, 112, 117, 200, 121),
               pick_gap(), 1'b0);
    queue_line(make_line(ModeLuma, 3'd3, 255, 31, 31, 60, 40, 50, 0, 180, 200, 190, 255),
               pick_gap(), 1'b0);
    // sample clipping at the top and at zero (negative delta rounds down)
    queue_line(make_line(ModeLuma, 3'd2, 255, 31, 25, 254, 255, 250, 250, 255, 225, 230, 230),
               pick_gap(), 1'b0);
    queue_line(make_line(ModeLuma, 3'd2, 255, 31, 25, 1, 0, 5, 5, 0, 30, 25, 25),
               pick_gap(), 1'b0);
    queue_line(make_line(ModeLuma, 3'd1, 255, 31, 0, 0, 30, 28, 255, 30, 0, 2, 0),
               pick_gap(), 1'b0);

    burst = 1'b0;
    for (n = 0; n < RandLines; n++) begin
      if (n % 100 == 0) burst = ($urandom_range(0, 3) == 0);
      queue_line(gen_line(), burst ? 0 : pick_gap(), (n % 400) == 0);
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_lines.size() != 0 || in_valid || filtered_lines.size() != 0)
      @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ deblocking_edge_sample_filter_unit.f @@
rtl/dbf_pkg.sv
rtl/dbf_gate.sv
rtl/dbf_filt.sv
rtl/dbf_sel.sv
rtl/deblocking_edge_sample_filter_unit.sv
rtl/dbf_chk.sv
test/tb_top.sv
